>>> sv/bsf_pkg.sv
// bsf_pkg: shared constants and types for the byte stuffing framer
// no dependencies; imported by bsf_expand, bsf_out_reg and the top level
package bsf_pkg;

  // line codes
  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;

  // pieces of one input beat, in line order
  localparam int unsigned NumPieces = 4;
  localparam int unsigned PieceOpen  = 0;
  localparam int unsigned PieceEsc   = 1;
  localparam int unsigned PieceByte  = 2;
  localparam int unsigned PieceClose = 3;

  typedef logic [NumPieces-1:0] piece_mask_t;

  // one output beat travelling from the expander to the output register
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } piece_t;

  // byte that needs an escape in front of it
  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = (b == FLAG_BYTE) || (b == ESCAPE_BYTE);
  endfunction

  // lowest set bit of a piece mask, as a one-hot mask
  function automatic piece_mask_t lowest_piece(input piece_mask_t m);
    lowest_piece = m & (~m + piece_mask_t'(1));
  endfunction

endpackage

>>> sv/bsf_expand.sv
// bsf_expand: input register and piece sequencer for the byte stuffing framer
// depends on bsf_pkg; feeds one piece per cycle to bsf_out_reg while load_i is high
module bsf_expand import bsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_frame_i,
  input  logic       last_of_frame_i,
  output logic       piece_valid_o,
  output piece_t     piece_o,
  input  logic       load_i
);

  logic        st_valid_q, st_valid_d;
  piece_mask_t mask_q, mask_d;
  logic [7:0]  data_q;
  piece_mask_t sel;
  piece_mask_t remaining;
  logic        in_accept;

  // pick the next piece and what is left after it
  assign sel       = lowest_piece(mask_q);
  assign remaining = mask_q & ~sel;

  always_comb begin
    piece_o.run_end = (remaining == '0);
    priority if (sel[PieceByte]) begin
      piece_o.out_byte = data_q;
    end else if (sel[PieceEsc]) begin
      piece_o.out_byte = ESCAPE_BYTE;
    end else begin
      piece_o.out_byte = FLAG_BYTE;
    end
  end

  assign piece_valid_o = st_valid_q;

  // free when empty or when the last piece leaves this cycle
  assign in_ready_o = !st_valid_q || (load_i && (remaining == '0));
  assign in_accept  = in_valid_i && in_ready_o;

  // next item state
  always_comb begin
    st_valid_d = st_valid_q;
    mask_d     = mask_q;
    if (in_accept) begin
      st_valid_d             = 1'b1;
      mask_d                 = '0;
      mask_d[PieceOpen]  = first_of_frame_i;
      mask_d[PieceEsc]   = needs_escape(data_byte_i);
      mask_d[PieceByte]  = 1'b1;
      mask_d[PieceClose] = last_of_frame_i;
    end else if (load_i) begin
      st_valid_d = (remaining != '0);
      mask_d     = remaining;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
      mask_q     <= '0;
    end else begin
      st_valid_q <= st_valid_d;
      mask_q     <= mask_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_byte_i;
    end
  end

`ifndef SYNTHESIS
  // a held item always has a piece left to send
  a_mask_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid_q |-> (mask_q != '0))
    else $error("held item with no pieces left");

  // a waiting item keeps its pieces
  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_q && !load_i) |=> (st_valid_q && $stable(mask_q)))
    else $error("pieces changed while output blocked");

  // an escape is always followed by its payload byte
  a_escape_then_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_q && sel[PieceEsc]) |-> (remaining[PieceByte] && !piece_o.run_end))
    else $error("escape not followed by payload byte");

  // the payload byte is never the first piece when an opening flag is pending
  a_open_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_q && mask_q[PieceOpen]) |-> sel[PieceOpen])
    else $error("opening flag not sent first");
`endif

endmodule

>>> sv/bsf_out_reg.sv
// bsf_out_reg: result register holding one framed beat for the receiver
// depends on bsf_pkg; loaded by bsf_expand
module bsf_out_reg import bsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       piece_valid_i,
  input  piece_t     piece_i,
  output logic       load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  logic   valid_q;
  piece_t data_q;

  // load when empty or when the held beat is taken
  assign load_o = piece_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      data_q <= piece_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = data_q.out_byte;
  assign run_end_o   = data_q.run_end;

endmodule

>>> sv/byte_stuffing_framer_core.sv
// byte_stuffing_framer_core: top level of the byte stuffing framer
// depends on bsf_pkg, bsf_expand and bsf_out_reg
//
// Input channel: one payload byte per beat (data_byte_i) with marks for the
// first and last byte of a frame, on in_valid_i / in_ready_o.
// Output channel: framed bytes on out_valid_o / out_ready_i. Each input beat
// gives one to four output beats: opening flag 0x7E if first_of_frame_i,
// escape 0x7D if the byte is 0x7E or 0x7D, the byte itself unchanged, and
// closing flag 0x7E if last_of_frame_i. run_end_o marks the last of them.
// Path: an accepted input beat is stored in the input register, and its
// pieces then move one by one into the result register, which drives the
// output. Throughput: one output beat per cycle while the receiver does not
// stall; an input beat holds the input stage until its last piece has left,
// so plain bytes flow at one per cycle, set by the piece sequencer in the
// input stage emitting one piece a cycle.
// The next input beat is taken in the cycle its predecessor's last piece
// moves into the result register, even while that result waits.
// Reset: asynchronous, active low; empties both registers, nothing else is
// kept. A receiver stall holds the result register and, behind it, the input
// stage; with a beat held there, in_ready_o drops until the pipeline moves.
module byte_stuffing_framer_core import bsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_frame_i,
  input  logic       last_of_frame_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  logic   piece_valid;
  piece_t piece;
  logic   load;

  // input register and piece sequencer
  bsf_expand u_expand (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .first_of_frame_i (first_of_frame_i),
    .last_of_frame_i  (last_of_frame_i),
    .piece_valid_o    (piece_valid),
    .piece_o          (piece),
    .load_i           (load)
  );

  // result register
  bsf_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .piece_valid_i (piece_valid),
    .piece_i       (piece),
    .load_o        (load),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_end_o     (run_end_o)
  );

endmodule
